// ===== sv/b32g_pkg.sv =====
// Shared types, constants and the symbol lookup for the grouped base-32 encoder.
// No dependencies; every other file but b32g_if refers to it by scoped names.
`default_nettype none

package b32g_pkg;

    localparam int SYM_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int GROUP_W  = 5;
    localparam int HELD_W   = 3;    // leftover bits between bytes: 0..4
    localparam int STORE_W  = 4;
    localparam int MAX_SYMS = 3;

    localparam logic [GROUP_W-1:0] GROUP_POS_MAX = 5'd31;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 1'b1;

    localparam logic [GROUP_W-1:0] GROUP_SIZE_RESET = 5'd5;
    localparam logic [CHAR_W-1:0]  SEPARATOR_RESET  = 8'd45;

    localparam logic [32*CHAR_W-1:0] SYMBOL_CHARS = "23456789ABCDEFGHJKLMNPQRSTUVWXYZ";

    typedef logic [SYM_W-1:0] sym_t;

    // one input byte: up to three symbols, the last one ends the message if last is set
    typedef struct packed {
        sym_t [MAX_SYMS-1:0] sym;
        logic [1:0]          nsym;
        logic                last;
    } entry_t;

    typedef struct packed {
        logic [GROUP_W-1:0] group_size;
        logic [CHAR_W-1:0]  separator_char;
    } cfg_t;

    function automatic logic [CHAR_W-1:0] symbol_char(input sym_t s);
        logic [4:0] idx;
        idx = 5'd31 - s;
        return SYMBOL_CHARS[CHAR_W*idx +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

// ===== sv/b32g_if.sv =====
// Valid/ready channel interfaces for the byte input and the character output.
// Stand-alone; used by the top level and the front and back modules.
`default_nettype none

interface b32g_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b32g_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_of_message;

    modport source (output valid, output out_char, output end_of_message, input ready);
    modport sink   (input valid, input out_char, input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== sv/b32g_front.sv =====
// Front end: accepts bytes, slices the bit stream into 5-bit symbols, pushes one entry per byte.
// Depends on b32g_pkg and b32g_byte_if.
`default_nettype none

module b32g_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    b32g_byte_if.sink              byte_ch,
    input  wire logic              q_full,
    output logic                   q_push,
    output b32g_pkg::entry_t       q_entry
);

    logic [b32g_pkg::STORE_W-1:0] store_reg, store_next;
    logic [b32g_pkg::HELD_W-1:0]  held_reg, held_next;

    logic [11:0] combined;
    logic [11:0] pad_word;
    logic [2:0]  shift0;
    logic [2:0]  shift1;
    logic [2:0]  rem;
    logic        two_syms;
    logic [11:0] word0;
    logic [11:0] word1;
    logic [3:0]  rem_mask;

    assign byte_ch.ready = !q_full;
    assign q_push        = byte_ch.valid && !q_full;

    always_comb
    begin
        combined = {store_reg, byte_ch.data_byte};
        // held = held_reg + 8; first symbol sits at held - 5
        shift0   = held_reg + 3'd3;
        two_syms = (held_reg >= 3'd2);
        shift1   = held_reg - 3'd2;
        rem      = two_syms ? (held_reg - 3'd2) : (held_reg + 3'd3);
        word0    = combined >> shift0;
        word1    = combined >> shift1;
        // leftover bits move to the top of the symbol, zero fill below
        pad_word = combined << (3'd5 - rem);
        rem_mask = 4'((5'd1 << rem) - 5'd1);

        q_entry.sym[0] = word0[4:0];
        q_entry.sym[1] = two_syms ? word1[4:0] : pad_word[4:0];
        q_entry.sym[2] = pad_word[4:0];
        q_entry.last   = byte_ch.last_byte;
        if (two_syms)
        begin
            q_entry.nsym = (byte_ch.last_byte && rem != 3'd0) ? 2'd3 : 2'd2;
        end
        else
        begin
            q_entry.nsym = byte_ch.last_byte ? 2'd2 : 2'd1;
        end

        store_next = store_reg;
        held_next  = held_reg;
        if (q_push)
        begin
            if (byte_ch.last_byte)
            begin
                store_next = '0;
                held_next  = '0;
            end
            else
            begin
                store_next = combined[3:0] & rem_mask;
                held_next  = rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            store_reg <= store_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b32g_queue.sv =====
// Small FIFO of symbol entries between the front and back ends.
// Depends on b32g_pkg.
`default_nettype none

module b32g_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire b32g_pkg::entry_t  push_entry,
    input  wire logic              pop,
    output b32g_pkg::entry_t       head,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    b32g_pkg::entry_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b32g_back.sv =====
// Back end: walks queued symbols, inserts separators, drives the registered character output.
// Depends on b32g_pkg and b32g_char_if.
`default_nettype none

module b32g_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire b32g_pkg::cfg_t    cfg,
    input  wire b32g_pkg::entry_t  head,
    input  wire logic              q_empty,
    output logic                   q_pop,
    b32g_char_if.source            char_ch
);

    logic [1:0]                   idx_reg, idx_next;
    logic [b32g_pkg::GROUP_W-1:0] gpos_reg, gpos_next;
    logic                         started_reg, started_next;
    logic                         out_valid_reg, out_valid_next;
    logic [b32g_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic                         eom_reg, eom_next;

    logic                         advance;
    logic                         work;
    logic                         sep_due;
    logic                         final_sym;
    b32g_pkg::sym_t               cur_sym;

    assign char_ch.valid          = out_valid_reg;
    assign char_ch.out_char       = out_char_reg;
    assign char_ch.end_of_message = eom_reg;

    always_comb
    begin
        advance   = !out_valid_reg || char_ch.ready;
        work      = advance && !q_empty;
        sep_due   = started_reg && (cfg.group_size != '0) && (gpos_reg >= cfg.group_size);
        cur_sym   = head.sym[idx_reg];
        final_sym = (idx_reg == head.nsym - 2'd1);

        idx_next       = idx_reg;
        gpos_next      = gpos_reg;
        started_next   = started_reg;
        out_char_next  = out_char_reg;
        eom_next       = eom_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !char_ch.ready;

        if (work)
        begin
            out_valid_next = 1'b1;
            if (sep_due)
            begin
                out_char_next = cfg.separator_char;
                eom_next      = 1'b0;
                gpos_next     = '0;
            end
            else
            begin
                out_char_next = b32g_pkg::symbol_char(cur_sym);
                eom_next      = final_sym && head.last;
                started_next  = 1'b1;
                if (gpos_reg != b32g_pkg::GROUP_POS_MAX)
                begin
                    gpos_next = gpos_reg + 1'b1;
                end
                if (final_sym)
                begin
                    idx_next = '0;
                    q_pop    = 1'b1;
                    if (head.last)
                    begin
                        gpos_next    = '0;
                        started_next = 1'b0;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            gpos_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            gpos_reg      <= gpos_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        eom_reg      <= eom_next;
    end

endmodule

`default_nettype wire

// ===== sv/base32_grouped_encoder.sv =====
// Grouped base-32 encoder (2-9, A-Z without I and O).
//
// byte_ch takes one message byte per beat, last_byte marks the final byte.
// char_ch gives one ASCII character per beat; separators go between groups
// of group_size characters, end_of_message marks the final character.
// Configuration: cfg_wr_en with cfg_index 0 writes group_size (cfg_data[4:0],
// 0 = no separators), index 1 writes separator_char. Write only while idle.
// The first character of a byte passes through the queue and the output register.
// The back end issues one character per cycle while the queue is not empty and
// the output is not stalled; a byte yields 1 to 3 characters plus separators.
// The output character rate sets the byte rate.
// The front end keeps taking bytes while the QUEUE_DEPTH entry queue has
// room, independent of a stalled output; a stalled output holds its beat.
// Reset clears the bit buffer, group count, queue and output valid, and
// loads group_size 5 and separator '-'.
// Depends on b32g_pkg, b32g_if, b32g_front, b32g_queue, b32g_back.
`default_nettype none

module base32_grouped_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    b32g_byte_if.sink                              byte_ch,
    b32g_char_if.source                            char_ch,
    input  wire logic                              cfg_wr_en,
    input  wire logic [b32g_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [b32g_pkg::CHAR_W-1:0]       cfg_data
);

    b32g_pkg::cfg_t   cfg_reg, cfg_next;
    b32g_pkg::entry_t push_entry;
    b32g_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                b32g_pkg::CFG_GROUP_SIZE: cfg_next.group_size     = cfg_data[b32g_pkg::GROUP_W-1:0];
                b32g_pkg::CFG_SEPARATOR:  cfg_next.separator_char = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_size     <= b32g_pkg::GROUP_SIZE_RESET;
            cfg_reg.separator_char <= b32g_pkg::SEPARATOR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    b32g_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .q_full  (full),
        .q_push  (push),
        .q_entry (push_entry)
    );

    b32g_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    b32g_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .q_empty (empty),
        .q_pop   (pop),
        .char_ch (char_ch)
    );

endmodule

`default_nettype wire

// ===== test/b32g_checker.sv =====
// Checker for the grouped base-32 encoder: watches the byte, character and
// register write ports, predicts every character beat and compares in order.
// Depends on b32g_pkg and the channel interfaces in b32g_if.
module b32g_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    b32g_byte_if                              byte_ch,
    b32g_char_if                              char_ch,
    input  logic                              cfg_wr_en,
    input  logic [b32g_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [b32g_pkg::CHAR_W-1:0]       cfg_data,
    output int                                errors,
    output int                                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [32*8-1:0] ALPHABET = "23456789ABCDEFGHJKLMNPQRSTUVWXYZ";

    typedef struct packed {
        logic [7:0] ch;
        logic       eom;
    } char_beat_t;

    char_beat_t expected_chars[$];

    logic [11:0]                  acc_bits;
    logic [3:0]                   acc_count;
    logic [4:0]                   group_count;
    logic                         msg_open;
    logic [b32g_pkg::GROUP_W-1:0] grp_size;
    logic [b32g_pkg::CHAR_W-1:0]  sep_code;

    // one character, preceded by a separator once the group is full
    task automatic emit_symbol(input logic [4:0] s, input logic eom);
        if (msg_open && grp_size != '0 && group_count >= grp_size) begin
            expected_chars.push_back(char_beat_t'{sep_code, 1'b0});
            group_count = '0;
        end
        expected_chars.push_back(char_beat_t'{ALPHABET[8*(31 - int'(s)) +: 8], eom});
        if (group_count != 5'd31)
            group_count = group_count + 5'd1;
        msg_open = 1'b1;
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic lst);
        logic [4:0]  s;
        logic [11:0] padded;
        acc_bits  = {acc_bits[3:0], b};
        acc_count = {1'b0, acc_count[2:0]} + 4'd8;
        while (acc_count >= 4'd5) begin
            acc_count = acc_count - 4'd5;
            s = acc_bits[acc_count +: 5];
            emit_symbol(s, lst && acc_count == 4'd0);
        end
        if (lst) begin
            // leftover bits go out zero-padded on the right
            if (acc_count != 4'd0) begin
                padded = acc_bits << (4'd5 - acc_count);
                emit_symbol(padded[4:0], 1'b1);
            end
            acc_bits    = '0;
            acc_count   = '0;
            group_count = '0;
            msg_open    = 1'b0;
        end else begin
            acc_bits = acc_bits & ((12'd1 << acc_count) - 12'd1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        char_beat_t got;
        char_beat_t want;
        if (!rst_n)
        begin
            acc_bits    = '0;
            acc_count   = '0;
            group_count = '0;
            msg_open    = 1'b0;
            grp_size    = b32g_pkg::GROUP_SIZE_RESET;
            sep_code    = b32g_pkg::SEPARATOR_RESET;
            errors      = 0;
            expected_chars.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    b32g_pkg::CFG_GROUP_SIZE: grp_size = cfg_data[b32g_pkg::GROUP_W-1:0];
                    b32g_pkg::CFG_SEPARATOR:  sep_code = cfg_data;
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready)
                encode_byte(byte_ch.data_byte, byte_ch.last_byte);
            if (char_ch.valid && char_ch.ready) begin
                got = char_beat_t'{char_ch.out_char, char_ch.end_of_message};
                if (expected_chars.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected char beat, expected none, got %h eom %b",
                             $time, got.ch, got.eom);
                end else begin
                    want = expected_chars.pop_front();
                    if (got.ch !== want.ch) begin
                        errors++;
                        $display("%0t ns: out_char mismatch, expected %h, got %h",
                                 $time, want.ch, got.ch);
                    end
                    if (got.eom !== want.eom) begin
                        errors++;
                        $display("%0t ns: end_of_message mismatch, expected %b, got %b",
                                 $time, want.eom, got.eom);
                    end
                end
            end
            outstanding <= expected_chars.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the grouped base-32 encoder testbench: clock, reset, byte and
// register stimulus, output backpressure and the verdict.
// Depends on b32g_pkg, b32g_if, the encoder RTL and b32g_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 60;
    localparam int NUM_PHASES    = 7;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [b32g_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [b32g_pkg::CHAR_W-1:0]    cfg_data;

    int errors;
    int outstanding;
    int cycle_count;
    int msg_left;
    bit hold_off_req;
    bit tx_steady;
    bit rx_steady;

    b32g_byte_if byte_ch();
    b32g_char_if char_ch();

    base32_grouped_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .char_ch   (char_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    b32g_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_ch     (byte_ch),
        .char_ch     (char_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 5);
        else if (r < 90)
            return $urandom_range(6, 12);
        return $urandom_range(13, 24);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [b32g_pkg::CFG_IDX_W-1:0] idx,
                             input logic [b32g_pkg::CHAR_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // junk in the upper bits must be masked off by the block
    task automatic write_group_size(input logic [b32g_pkg::GROUP_W-1:0] gs);
        logic [b32g_pkg::CHAR_W-1:0] v;
        v = 8'($urandom);
        v[b32g_pkg::GROUP_W-1:0] = gs;
        write_reg(b32g_pkg::CFG_GROUP_SIZE, v);
    endtask

    // stop sending and let every pending character come out
    task automatic settle();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // messages may stay open across phases, so config also changes mid-message
    task automatic send_random_bytes(input int count);
        for (int i = 0; i < count; i++) begin
            if (msg_left == 0)
                msg_left = pick_msg_len();
            msg_left--;
            send_byte(pick_byte(), msg_left == 0);
        end
    endtask

    initial
    begin : rx_side
        int n;
        char_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                char_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (rx_steady) begin
                char_ch.ready <= 1'b1;
                @(posedge clk);
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    char_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end else begin
                    char_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [b32g_pkg::GROUP_W-1:0] phase_group[NUM_PHASES];
        logic [b32g_pkg::CHAR_W-1:0]  phase_sep[NUM_PHASES];
        int waited;

        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = b32g_pkg::CFG_GROUP_SIZE;
        cfg_data          = '0;
        hold_off_req      = 1'b0;
        tx_steady         = 1'b0;
        rx_steady         = 1'b0;
        msg_left          = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: groups of five, '-' separator
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h81, 1'b1);

        // group size shrinks in the middle of a message
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        settle();
        write_group_size(5'd2);
        send_byte(8'h56, 1'b1);

        // separators off, separator code that is also an alphabet char
        settle();
        write_group_size(5'd0);
        write_reg(b32g_pkg::CFG_SEPARATOR, "A");
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h99, 1'b1);

        // separator after every character
        settle();
        write_group_size(5'd1);
        write_reg(b32g_pkg::CFG_SEPARATOR, 8'hFF);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);

        settle();
        write_group_size(5'd31);
        write_reg(b32g_pkg::CFG_SEPARATOR, 8'h00);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b1);

        phase_group = '{5'd0, 5'd1, 5'd31, 5'd5, 5'd3, 5'($urandom), 5'd7};
        phase_sep   = '{8'($urandom), 8'h00, 8'hFF, 8'd45, "Z", 8'($urandom), 8'h2E};

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_group_size(phase_group[p]);
            write_reg(b32g_pkg::CFG_SEPARATOR, phase_sep[p]);
            tx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
            rx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
            // long output stall while bytes keep coming, so the input backs up
            if (p == 4)
                hold_off_req = 1'b1;
            send_random_bytes(PHASE_ITEMS);
        end

        byte_ch.valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (outstanding != 0)
            $display("%0t ns: %0d expected characters never arrived", $time, outstanding);
        if (errors == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
